@@ hdl/alt_pkg.sv @@
// Shared types and codes for the array list table.
`timescale 1ns / 1ps

package alt_pkg;

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_ERASE      = 3'd1,
        OP_FIND       = 3'd2,
        OP_MODIFY     = 3'd3,
        OP_PUSH_BACK  = 3'd4,
        OP_PUSH_FRONT = 3'd5,
        OP_POP_BACK   = 3'd6,
        OP_POP_FRONT  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD       = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_LOWER,
        CELL_TAKE_UPPER,
        CELL_LOAD
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [5:0] found_index;
        logic [6:0] element_count;
    } t_out_item;

endpackage

@@ hdl/alt_stream_if.sv @@
// Valid/ready stream channel carrying one payload per beat.
`timescale 1ns / 1ps

interface alt_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/array_list_table_unit.sv @@
// Array list table: packed ordered list kept in a chain of entry cells.
//
// Channels: i_in takes one operation per beat (operation, position, value);
// o_out returns one result per operation (status, found_index,
// element_count). Both are valid/ready streams.
// Insert, erase, modify, push and pop-front update the cells at once:
// every cell loads, holds or takes its neighbor's value at the accepting
// edge (pop-back only lowers the count); results are registered for o_out.
// Find compares every cell in the accepting cycle, then scans the match
// bits eight entries per cycle; the next operation is accepted once the
// scan ends.
// Only one operation is in progress at a time; a two-slot result buffer lets
// the next operation in while an earlier result waits on o_out.
// Reset empties the list (count zero); entry contents are not cleared.
// When the receiver stalls, results hold on o_out and i_in.ready drops
// once both buffer slots are full.
`timescale 1ns / 1ps

module array_list_table_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    alt_stream_if.sink   i_in,
    alt_stream_if.source o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam int G  = 8;
    localparam int GW = $clog2(G);
    localparam int NG = (DEPTH + G - 1) / G;
    localparam int MW = NG * G;
    localparam int BW = $clog2(DEPTH + G + 1);

    alt_pkg::t_state    r_state;
    alt_pkg::t_state    n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [MW-1:0]      r_match;
    logic [MW-1:0]      n_match;
    logic [BW-1:0]      r_base;
    logic [BW-1:0]      n_base;

    logic                  w_accept;
    logic                  w_space;
    logic                  w_push;
    alt_pkg::t_out_item    w_item;
    logic                  w_ins_en;
    logic                  w_del_en;
    logic                  w_mod_en;
    logic [PW-1:0]         w_ins_at;
    logic [PW-1:0]         w_del_at;
    logic [PW-1:0]         w_pos_x;
    logic [PW-1:0]         w_cnt_x;
    logic                  w_full;
    logic signed [63:0]    w_sx;
    logic [DATA_WIDTH-1:0] w_key;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]      w_hit;
    logic [MW-1:0]         w_match_vec;
    alt_pkg::t_cell_cmd    w_cmd [DEPTH];
    logic [G-1:0]          w_low;
    logic [GW-1:0]         w_enc;
    logic [BW-1:0]         w_hit_idx;

    assign i_in.ready = (r_state == alt_pkg::S_IDLE) && w_space;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_sx    = 64'(i_in.payload.value);
    assign w_key   = w_sx[DATA_WIDTH-1:0];
    assign w_pos_x = PW'(i_in.payload.position);
    assign w_cnt_x = PW'(r_count);
    assign w_full  = (r_count == CW'(DEPTH));

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_lower;
            logic [DATA_WIDTH-1:0] w_upper;

            if (k == 0) begin : g_first
                assign w_lower = w_data[k];
            end else begin : g_mid_lo
                assign w_lower = w_data[k-1];
            end

            if (k == DEPTH - 1) begin : g_last
                assign w_upper = w_data[k];
            end else begin : g_mid_hi
                assign w_upper = w_data[k+1];
            end

            always_comb begin
                w_cmd[k] = alt_pkg::CELL_HOLD;
                if (w_ins_en) begin
                    if (PW'(k) == w_ins_at) begin
                        w_cmd[k] = alt_pkg::CELL_LOAD;
                    end else if (PW'(k) > w_ins_at) begin
                        w_cmd[k] = alt_pkg::CELL_TAKE_LOWER;
                    end
                end else if (w_del_en) begin
                    if (PW'(k) >= w_del_at) begin
                        w_cmd[k] = alt_pkg::CELL_TAKE_UPPER;
                    end
                end else if (w_mod_en) begin
                    if (PW'(k) == w_pos_x) begin
                        w_cmd[k] = alt_pkg::CELL_LOAD;
                    end
                end
            end

            alt_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd[k]),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .i_load  (w_key),
                .i_key   (w_key),
                .o_data  (w_data[k]),
                .o_match (w_hit[k])
            );

            assign w_match_vec[k] = w_hit[k] && (PW'(k) < w_cnt_x);
        end

        if (MW > DEPTH) begin : g_pad
            assign w_match_vec[MW-1:DEPTH] = '0;
        end
    endgenerate

    assign w_low = r_match[G-1:0];

    always_comb begin
        w_enc = '0;
        for (int b = G - 1; b >= 0; b--) begin
            if (w_low[b]) begin
                w_enc = GW'(b);
            end
        end
    end

    assign w_hit_idx = r_base + BW'(w_enc);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_match  = r_match;
        n_base   = r_base;
        w_push   = 1'b0;
        w_item   = '0;
        w_ins_en = 1'b0;
        w_del_en = 1'b0;
        w_mod_en = 1'b0;
        w_ins_at = w_pos_x;
        w_del_at = w_pos_x;

        unique case (r_state)
            alt_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_push = 1'b1;
                    w_item.status = alt_pkg::STAT_OK;
                    unique case (i_in.payload.operation)
                        alt_pkg::OP_INSERT: begin
                            if (w_pos_x > w_cnt_x) begin
                                w_item.status = alt_pkg::STAT_BAD;
                            end else if (w_full) begin
                                w_item.status = alt_pkg::STAT_FULL;
                            end else begin
                                w_ins_en = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        alt_pkg::OP_PUSH_BACK: begin
                            w_ins_at = w_cnt_x;
                            if (w_full) begin
                                w_item.status = alt_pkg::STAT_FULL;
                            end else begin
                                w_ins_en = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        alt_pkg::OP_PUSH_FRONT: begin
                            w_ins_at = '0;
                            if (w_full) begin
                                w_item.status = alt_pkg::STAT_FULL;
                            end else begin
                                w_ins_en = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        alt_pkg::OP_ERASE: begin
                            if (w_pos_x >= w_cnt_x) begin
                                w_item.status = alt_pkg::STAT_BAD;
                            end else begin
                                w_del_en = 1'b1;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        alt_pkg::OP_POP_FRONT: begin
                            w_del_at = '0;
                            if (r_count == '0) begin
                                w_item.status = alt_pkg::STAT_BAD;
                            end else begin
                                w_del_en = 1'b1;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        alt_pkg::OP_POP_BACK: begin
                            if (r_count == '0) begin
                                w_item.status = alt_pkg::STAT_BAD;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        alt_pkg::OP_MODIFY: begin
                            if (w_pos_x >= w_cnt_x) begin
                                w_item.status = alt_pkg::STAT_BAD;
                            end else begin
                                w_mod_en = 1'b1;
                            end
                        end
                        alt_pkg::OP_FIND: begin
                            w_push  = 1'b0;
                            n_match = w_match_vec;
                            n_base  = '0;
                            n_state = alt_pkg::S_SCAN;
                        end
                        default: begin
                            w_push = 1'b0;
                        end
                    endcase
                    w_item.element_count = 7'(n_count);
                end
            end
            alt_pkg::S_SCAN: begin
                w_item.element_count = 7'(r_count);
                if (r_base >= BW'(r_count)) begin
                    w_push        = 1'b1;
                    w_item.status = alt_pkg::STAT_NOT_FOUND;
                    n_state       = alt_pkg::S_IDLE;
                end else if (|w_low) begin
                    w_push             = 1'b1;
                    w_item.status      = alt_pkg::STAT_OK;
                    w_item.found_index = 6'(w_hit_idx);
                    n_state            = alt_pkg::S_IDLE;
                end else begin
                    n_match = r_match >> G;
                    n_base  = r_base + BW'(G);
                end
            end
            default: begin
                n_state = alt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
        r_base  <= n_base;
    end

    alt_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_space (w_space),
        .o_out   (o_out)
    );

endmodule

@@ hdl/alt_cell.sv @@
// One list entry: holds a value, shifts to/from its neighbors, compares to a key.
`timescale 1ns / 1ps

module alt_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  alt_pkg::t_cell_cmd    i_cmd,
    input  logic [DATA_WIDTH-1:0] i_lower,
    input  logic [DATA_WIDTH-1:0] i_upper,
    input  logic [DATA_WIDTH-1:0] i_load,
    input  logic [DATA_WIDTH-1:0] i_key,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        unique case (i_cmd)
            alt_pkg::CELL_HOLD:       n_data = r_data;
            alt_pkg::CELL_TAKE_LOWER: n_data = i_lower;
            alt_pkg::CELL_TAKE_UPPER: n_data = i_upper;
            alt_pkg::CELL_LOAD:       n_data = i_load;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

@@ hdl/alt_result_buf.sv @@
// Two-slot result buffer between the list logic and the output channel.
`timescale 1ns / 1ps

module alt_result_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  alt_pkg::t_out_item i_item,
    output logic               o_space,
    alt_stream_if.source       o_out
);

    logic [1:0]         r_level;
    logic [1:0]         n_level;
    alt_pkg::t_out_item r_head;
    alt_pkg::t_out_item r_tail;
    logic               w_pop;

    assign w_pop   = o_out.valid && o_out.ready;
    assign o_space = (r_level != 2'd2);

    always_comb begin
        n_level = r_level;
        if (i_push && !w_pop) begin
            n_level = r_level + 2'd1;
        end else if (w_pop && !i_push) begin
            n_level = r_level - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 2'd0;
        end else begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_level == 2'd2) begin
            if (w_pop) begin
                r_head <= r_tail;
            end
        end else if (r_level == 2'd1) begin
            if (i_push && w_pop) begin
                r_head <= i_item;
            end else if (i_push) begin
                r_tail <= i_item;
            end
        end else if (i_push) begin
            r_head <= i_item;
        end
    end

    assign o_out.valid   = (r_level != 2'd0);
    assign o_out.payload = r_head;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the array list table: directed table, then random operation mix.
`timescale 1ns / 1ps

module testbench;

    localparam int LIST_DEPTH   = 64;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int N_DIRECTED   = 23;
    localparam int N_PHASES     = 6;

    typedef struct packed {
        alt_pkg::t_op     op;
        logic [5:0]       pos;
        logic [31:0]      val;
        logic             has_golden;
        alt_pkg::t_status g_status;
        logic [5:0]       g_index;
        logic [6:0]       g_count;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    alt_stream_if #(.T_PAYLOAD(alt_pkg::t_in_item))  in_ch ();
    alt_stream_if #(.T_PAYLOAD(alt_pkg::t_out_item)) out_ch ();

    array_list_table_unit #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [31:0] list_mirror [LIST_DEPTH];
    int          list_count = 0;

    alt_pkg::t_out_item pending_results [$];
    bit                 golden_flags [$];
    alt_pkg::t_out_item golden_results [$];

    int  error_count   = 0;
    int  cycle_count   = 0;
    int  accept_count  = 0;
    int  result_count  = 0;
    int  full_hits     = 0;
    int  bad_hits      = 0;
    int  found_hits    = 0;
    int  peak_count    = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_go       = 1'b0;
    logic hold_active  = 1'b0;

    alt_pkg::t_out_item predicted_res;
    alt_pkg::t_out_item golden_res;
    alt_pkg::t_out_item wanted_res;
    bit                 golden_flag;

    t_dir_row directed_rows [N_DIRECTED];
    int phase_idle  [N_PHASES] = '{0, 78, 0, 7, 0, 0};
    int phase_stall [N_PHASES] = '{0, 0, 78, 7, 0, 0};
    int phase_grow  [N_PHASES] = '{50, 75, 55, 25, 60, 90};
    int phase_items [N_PHASES] = '{200, 200, 200, 200, 200, 130};

    always #2 i_clk = ~i_clk;

    function automatic alt_pkg::t_out_item apply_list_op(input alt_pkg::t_in_item item);
        alt_pkg::t_out_item res;
        int                 k;
        bit                 hit;
        res.status      = alt_pkg::STAT_OK;
        res.found_index = '0;
        hit = 1'b0;
        case (item.operation)
            alt_pkg::OP_INSERT: begin
                if (item.position > list_count) begin
                    res.status = alt_pkg::STAT_BAD;
                end else if (list_count >= LIST_DEPTH) begin
                    res.status = alt_pkg::STAT_FULL;
                end else begin
                    for (k = list_count; k > item.position; k--)
                        list_mirror[k] = list_mirror[k - 1];
                    list_mirror[item.position] = item.value;
                    list_count++;
                end
            end
            alt_pkg::OP_ERASE: begin
                if (item.position >= list_count) begin
                    res.status = alt_pkg::STAT_BAD;
                end else begin
                    for (k = item.position; k + 1 < list_count; k++)
                        list_mirror[k] = list_mirror[k + 1];
                    list_count--;
                end
            end
            alt_pkg::OP_FIND: begin
                res.status = alt_pkg::STAT_NOT_FOUND;
                for (k = 0; k < list_count; k++) begin
                    if (!hit && list_mirror[k] == item.value) begin
                        hit             = 1'b1;
                        res.status      = alt_pkg::STAT_OK;
                        res.found_index = k[5:0];
                    end
                end
            end
            alt_pkg::OP_MODIFY: begin
                if (item.position >= list_count)
                    res.status = alt_pkg::STAT_BAD;
                else
                    list_mirror[item.position] = item.value;
            end
            alt_pkg::OP_PUSH_BACK, alt_pkg::OP_PUSH_FRONT: begin
                if (list_count >= LIST_DEPTH) begin
                    res.status = alt_pkg::STAT_FULL;
                end else begin
                    if (item.operation == alt_pkg::OP_PUSH_FRONT) begin
                        for (k = list_count; k > 0; k--)
                            list_mirror[k] = list_mirror[k - 1];
                        list_mirror[0] = item.value;
                    end else begin
                        list_mirror[list_count] = item.value;
                    end
                    list_count++;
                end
            end
            alt_pkg::OP_POP_BACK: begin
                if (list_count == 0)
                    res.status = alt_pkg::STAT_BAD;
                else
                    list_count--;
            end
            default: begin
                if (list_count == 0) begin
                    res.status = alt_pkg::STAT_BAD;
                end else begin
                    for (k = 0; k + 1 < list_count; k++)
                        list_mirror[k] = list_mirror[k + 1];
                    list_count--;
                end
            end
        endcase
        res.element_count = list_count[6:0];
        return res;
    endfunction

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4, 5:    return 32'($signed($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic alt_pkg::t_in_item make_list_op(input int grow_pct);
        alt_pkg::t_in_item item;
        int                cnt;
        int                roll;
        cnt = list_count;
        item.operation = alt_pkg::OP_FIND;
        item.position  = 6'($urandom_range(0, 63));
        item.value     = pick_value();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            item.operation = alt_pkg::t_op'($urandom_range(0, 7));
            item.value     = $urandom;
            return item;
        end
        roll = $urandom_range(0, 99);
        if (roll < 22)
            item.operation = alt_pkg::OP_FIND;
        else if (roll < 32)
            item.operation = alt_pkg::OP_MODIFY;
        else if ($urandom_range(0, 99) < grow_pct)
            item.operation = alt_pkg::t_op'($urandom_range(0, 2) == 0 ? alt_pkg::OP_INSERT :
                                 ($urandom_range(0, 1) ? alt_pkg::OP_PUSH_BACK :
                                                         alt_pkg::OP_PUSH_FRONT));
        else
            item.operation = alt_pkg::t_op'($urandom_range(0, 2) == 0 ? alt_pkg::OP_ERASE :
                                 ($urandom_range(0, 1) ? alt_pkg::OP_POP_BACK :
                                                         alt_pkg::OP_POP_FRONT));
        case (item.operation)
            alt_pkg::OP_INSERT: begin
                if (cnt < LIST_DEPTH && $urandom_range(0, 9) == 0)
                    item.position = 6'($urandom_range(cnt, 63));
                else
                    item.position = 6'($urandom_range(0, cnt < LIST_DEPTH ? cnt : 63));
            end
            alt_pkg::OP_ERASE, alt_pkg::OP_MODIFY: begin
                if (cnt == 0 || $urandom_range(0, 9) == 0)
                    item.position = 6'($urandom_range(cnt < LIST_DEPTH ? cnt : 0, 63));
                else
                    item.position = 6'($urandom_range(0, cnt - 1));
            end
            alt_pkg::OP_FIND: begin
                if (cnt > 0 && $urandom_range(0, 9) < 6)
                    item.value = list_mirror[$urandom_range(0, cnt - 1)];
            end
            default: ;
        endcase
        return item;
    endfunction

    task automatic report_mismatch(input string field_name, input int got, input int want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0d, want %0d",
                 cycle_count, field_name, got, want);
    endtask

    task automatic send_beat(input alt_pkg::t_in_item item, input bit has_golden,
                             input alt_pkg::t_out_item golden);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        golden_flags.push_back(has_golden);
        golden_results.push_back(golden);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predicted_res = apply_list_op(in_ch.payload);
                golden_flag   = golden_flags.pop_front();
                golden_res    = golden_results.pop_front();
                pending_results.push_back(golden_flag ? golden_res : predicted_res);
                accept_count++;
                if (predicted_res.status == alt_pkg::STAT_FULL)
                    full_hits++;
                if (predicted_res.status == alt_pkg::STAT_BAD)
                    bad_hits++;
                if (in_ch.payload.operation == alt_pkg::OP_FIND &&
                    predicted_res.status == alt_pkg::STAT_OK)
                    found_hits++;
                if (list_count > peak_count)
                    peak_count = list_count;
            end
            if (out_ch.valid && out_ch.ready) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, status", out_ch.payload.status, -1);
                end else begin
                    wanted_res = pending_results.pop_front();
                    if (out_ch.payload.status !== wanted_res.status)
                        report_mismatch("status", out_ch.payload.status, wanted_res.status);
                    if (out_ch.payload.found_index !== wanted_res.found_index)
                        report_mismatch("found_index", out_ch.payload.found_index,
                                        wanted_res.found_index);
                    if (out_ch.payload.element_count !== wanted_res.element_count)
                        report_mismatch("element_count", out_ch.payload.element_count,
                                        wanted_res.element_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("array_list_table_unit test failed");
            $finish;
        end
    end

    initial begin
        alt_pkg::t_in_item  item;
        alt_pkg::t_out_item golden;
        int                 i;
        int                 p;

        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        for (i = 0; i < LIST_DEPTH; i++)
            list_mirror[i] = '0;

        directed_rows = '{
            {alt_pkg::OP_POP_BACK,   6'd0,  32'h0000_0000, 1'b1, alt_pkg::STAT_BAD,
             6'd0, 7'd0},
            {alt_pkg::OP_POP_FRONT,  6'd0,  32'h0000_0000, 1'b1, alt_pkg::STAT_BAD,
             6'd0, 7'd0},
            {alt_pkg::OP_ERASE,      6'd0,  32'h0000_0000, 1'b1, alt_pkg::STAT_BAD,
             6'd0, 7'd0},
            {alt_pkg::OP_MODIFY,     6'd63, 32'hFFFF_FFFF, 1'b1, alt_pkg::STAT_BAD,
             6'd0, 7'd0},
            {alt_pkg::OP_FIND,       6'd0,  32'h0000_0000, 1'b1, alt_pkg::STAT_NOT_FOUND,
             6'd0, 7'd0},
            {alt_pkg::OP_INSERT,     6'd1,  32'h0000_0001, 1'b1, alt_pkg::STAT_BAD,
             6'd0, 7'd0},
            {alt_pkg::OP_INSERT,     6'd0,  32'h8000_0000, 1'b1, alt_pkg::STAT_OK,
             6'd0, 7'd1},
            {alt_pkg::OP_PUSH_BACK,  6'd63, 32'h7FFF_FFFF, 1'b1, alt_pkg::STAT_OK,
             6'd0, 7'd2},
            {alt_pkg::OP_PUSH_FRONT, 6'd0,  32'hFFFF_FFFF, 1'b1, alt_pkg::STAT_OK,
             6'd0, 7'd3},
            {alt_pkg::OP_FIND,       6'd0,  32'h7FFF_FFFF, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_FIND,       6'd0,  32'h0000_0000, 1'b1, alt_pkg::STAT_NOT_FOUND,
             6'd0, 7'd3},
            {alt_pkg::OP_MODIFY,     6'd3,  32'h0000_0000, 1'b1, alt_pkg::STAT_BAD,
             6'd0, 7'd3},
            {alt_pkg::OP_MODIFY,     6'd1,  32'h0000_0000, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_INSERT,     6'd3,  32'h0000_0005, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_INSERT,     6'd63, 32'h0000_0006, 1'b1, alt_pkg::STAT_BAD,
             6'd0, 7'd4},
            {alt_pkg::OP_ERASE,      6'd4,  32'h0000_0000, 1'b1, alt_pkg::STAT_BAD,
             6'd0, 7'd4},
            {alt_pkg::OP_ERASE,      6'd0,  32'h1234_5678, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_POP_BACK,   6'd63, 32'hFFFF_FFFF, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_POP_FRONT,  6'd63, 32'hFFFF_FFFF, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_FIND,       6'd0,  32'h7FFF_FFFF, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_PUSH_BACK,  6'd0,  32'h7FFF_FFFF, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_FIND,       6'd0,  32'h7FFF_FFFF, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0},
            {alt_pkg::OP_FIND,       6'd63, 32'h0000_0000, 1'b0, alt_pkg::STAT_OK,
             6'd0, 7'd0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            item.operation = directed_rows[i].op;
            item.position  = directed_rows[i].pos;
            item.value     = directed_rows[i].val;
            golden = {directed_rows[i].g_status, directed_rows[i].g_index,
                      directed_rows[i].g_count};
            send_beat(item, directed_rows[i].has_golden, golden);
        end

        for (p = 0; p < N_PHASES; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            if (p == 4)
                hold_go = 1'b1;
            for (i = 0; i < phase_items[p]; i++)
                send_beat(make_list_op(phase_grow[p]), 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d operations and checked %0d results in %0d cycles",
                 accept_count, result_count, cycle_count);
        $display("full rejections %0d, bad position or empty %0d, finds hit %0d, peak length %0d",
                 full_hits, bad_hits, found_hits, peak_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("array_list_table_unit test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     pending_results.size());
            $display("array_list_table_unit test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/alt_pkg.sv
hdl/alt_stream_if.sv
hdl/alt_cell.sv
hdl/alt_result_buf.sv
hdl/array_list_table_unit.sv
tb/testbench.sv
